// ===== rtl/cmsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsfd_pkg
// Shared types and constants for the multi-source CAN frame deframer.
// ----------------------------------------------------------------------------
package cmsfd_pkg;

  // Field widths fixed by the item format
  localparam int SID_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CHAN_W = 2;
  localparam int IDX_W  = 8;
  localparam int WORD_W = 16;

  // CAN identifiers that select channels 0, 1 and 2
  localparam int NUM_FIXED_IDS = 3;
  localparam logic [SID_W-1:0] CHAN0_ID = 11'h090;
  localparam logic [SID_W-1:0] CHAN1_ID = 11'h108;
  localparam logic [SID_W-1:0] CHAN2_ID = 11'h7F8;

  // Sync and footer pattern bytes (a-b-a-b)
  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAA;
  localparam logic [BYTE_W-1:0] FTR_FIRST  = 8'h66;
  localparam logic [BYTE_W-1:0] FTR_SECOND = 8'hCC;

  // Bytes after the sync pattern that are not counted in the payload length
  localparam int FRAME_OVERHEAD = 8;

  // Progress through an a-b-a-b pattern
  typedef enum logic [1:0] {
    SYNC_IDLE = 2'd0,
    SYNC_A    = 2'd1,
    SYNC_AB   = 2'd2,
    SYNC_ABA  = 2'd3
  } sync_st_t;

  // Per-channel result for one item
  typedef struct packed {
    logic              stored;
    logic [IDX_W-1:0]  byte_index;
    logic              message_done;
    logic              message_ok;
    logic [WORD_W-1:0] message_id;
    logic [WORD_W-1:0] payload_length;
  } chan_res_t;

endpackage

// ===== rtl/cmsfd_in_if.sv =====
// ----------------------------------------------------------------------------
// cmsfd_in_if
// Input channel: one CAN payload byte with its frame identifier.
// ----------------------------------------------------------------------------
interface cmsfd_in_if
  import cmsfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SID_W-1:0]  source_id;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output source_id, output data_byte, input ready);
  modport sink   (input valid, input source_id, input data_byte, output ready);
endinterface

// ===== rtl/cmsfd_out_if.sv =====
// ----------------------------------------------------------------------------
// cmsfd_out_if
// Result channel: one deframer result item per byte of a known identifier.
// ----------------------------------------------------------------------------
interface cmsfd_out_if
  import cmsfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [BYTE_W-1:0] byte_out;
  logic              stored;
  logic [IDX_W-1:0]  byte_index;
  logic              message_done;
  logic              message_ok;
  logic [WORD_W-1:0] message_id;
  logic [WORD_W-1:0] payload_length;

  modport source (output valid, output channel, output byte_out, output stored,
                  output byte_index, output message_done, output message_ok,
                  output message_id, output payload_length, input ready);
  modport sink   (input valid, input channel, input byte_out, input stored,
                  input byte_index, input message_done, input message_ok,
                  input message_id, input payload_length, output ready);
endinterface

// ===== rtl/cmsfd_chan.sv =====
// ----------------------------------------------------------------------------
// cmsfd_chan
// State and per-byte update of one deframer channel: header hunt, byte
// collection with id/length capture, footer detection.
// ----------------------------------------------------------------------------
module cmsfd_chan
  import cmsfd_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [BYTE_W-1:0] data_byte,
  output chan_res_t         res
);

  // Count reaches at most MAX_MESSAGE_BYTES + 1 before collection aborts
  localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam int CMP_W = WORD_W + 1;

  typedef struct packed {
    logic     hit;
    sync_st_t st;
  } sync_step_t;

  // One step of an a-b-a-b pattern search
  function automatic sync_step_t sync_advance(sync_st_t s, logic [BYTE_W-1:0] b,
                                              logic [BYTE_W-1:0] first,
                                              logic [BYTE_W-1:0] second);
    sync_step_t r;
    r.hit = 1'b0;
    r.st  = SYNC_IDLE;
    if (b == first) begin
      if (s == SYNC_IDLE)    r.st = SYNC_A;
      else if (s == SYNC_AB) r.st = SYNC_ABA;
    end else if (b == second) begin
      if (s == SYNC_A)        r.st = SYNC_AB;
      else if (s == SYNC_ABA) r.hit = 1'b1;
    end
    return r;
  endfunction

  sync_st_t          hdr_st_r, hdr_st_nxt;
  sync_st_t          ftr_st_r, ftr_st_nxt;
  logic              coll_r, coll_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] len_lo_r, len_lo_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] id_r, id_nxt;

  sync_step_t        hdr_step, ftr_step;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CMP_W-1:0]  len_limit;

  // Per-byte update: collection, then header search, then footer search
  always_comb begin
    hdr_st_nxt = hdr_st_r;
    ftr_st_nxt = ftr_st_r;
    coll_nxt   = coll_r;
    cnt_nxt    = cnt_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    id_nxt     = id_r;
    res        = '0;
    cnt_inc    = cnt_r + CNT_W'(1);
    hdr_step   = sync_advance(hdr_st_r, data_byte, HDR_FIRST, HDR_SECOND);
    ftr_step   = sync_advance(ftr_st_r, data_byte, FTR_FIRST, FTR_SECOND);

    // collection
    if (coll_r) begin
      if (cnt_r < CNT_W'(MAX_MESSAGE_BYTES)) begin
        res.stored     = 1'b1;
        res.byte_index = IDX_W'(cnt_r);
        if (cnt_r == CNT_W'(0))      id_nxt = {id_r[WORD_W-1:BYTE_W], data_byte};
        else if (cnt_r == CNT_W'(1)) id_nxt = {data_byte, id_r[BYTE_W-1:0]};
        else if (cnt_r == CNT_W'(2)) len_lo_nxt = data_byte;
        else if (cnt_r == CNT_W'(3)) len_nxt = {data_byte, len_lo_r};
      end
      cnt_nxt = cnt_inc;
    end
    len_limit = CMP_W'(len_nxt) + CMP_W'(FRAME_OVERHEAD);
    if (coll_r && ((CMP_W'(cnt_inc) > len_limit) ||
                   (cnt_inc > CNT_W'(MAX_MESSAGE_BYTES)))) begin
      coll_nxt = 1'b0;
    end

    // header search
    hdr_st_nxt = hdr_step.st;
    if (hdr_step.hit) begin
      coll_nxt = 1'b1;
      cnt_nxt  = '0;
    end

    // footer search
    ftr_st_nxt = ftr_step.st;
    if (ftr_step.hit && coll_nxt) begin
      res.message_done = 1'b1;
      res.message_ok   = (CMP_W'(cnt_nxt) == len_limit);
      coll_nxt         = 1'b0;
    end

    res.message_id     = id_nxt;
    res.payload_length = len_nxt;
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_st_r <= SYNC_IDLE;
      ftr_st_r <= SYNC_IDLE;
      coll_r   <= 1'b0;
      cnt_r    <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      id_r     <= '0;
    end else if (en) begin
      hdr_st_r <= hdr_st_nxt;
      ftr_st_r <= ftr_st_nxt;
      coll_r   <= coll_nxt;
      cnt_r    <= cnt_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      id_r     <= id_nxt;
    end
  end

endmodule

// ===== rtl/can_multi_source_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// can_multi_source_frame_deframer
// Per-identifier deframer for sync/footer delimited messages carried in CAN
// payload bytes.
// ----------------------------------------------------------------------------
// Takes one CAN payload byte per item and accepts a new item every clock
// cycle. An item passes an input register, then a single compute stage that
// reads and updates the selected channel's state and loads the result
// register; an item for a channel waits in that stage while the result
// register is full and not taken. Bytes whose identifier is not 0x090, 0x108
// or 0x7F8 (or whose channel is not below NUM_CHANNELS) are consumed and give
// no result. A byte that follows on the same channel in the next cycle sees
// the state its predecessor left. Throughput drops below one item per cycle
// only while the result channel stalls.
// ----------------------------------------------------------------------------
module can_multi_source_frame_deframer
  import cmsfd_pkg::*;
#(
  parameter int NUM_CHANNELS      = 3,
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  cmsfd_in_if.sink     in_ch,
  cmsfd_out_if.source  out_ch
);

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [SID_W-1:0]  s1_sid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] out_chan_r;
  logic [BYTE_W-1:0] out_byte_r;
  chan_res_t         out_res_r;

  logic              in_fire;
  logic              out_free;
  logic              s1_fire;
  logic              s1_known;
  logic              s1_hit;
  logic [CHAN_W-1:0] s1_chan;
  logic              out_load;
  logic [NUM_CHANNELS-1:0] chan_en;
  chan_res_t         chan_res [NUM_CHANNELS];
  chan_res_t         sel_res;

  // Identifier decode
  always_comb begin
    s1_known = 1'b1;
    s1_chan  = '0;
    if (s1_sid_r == CHAN0_ID)      s1_chan = CHAN_W'(0);
    else if (s1_sid_r == CHAN1_ID) s1_chan = CHAN_W'(1);
    else if (s1_sid_r == CHAN2_ID) s1_chan = CHAN_W'(2);
    else                           s1_known = 1'b0;
    s1_hit = s1_known && (int'(s1_chan) < NUM_CHANNELS);
  end

  // Handshake: unknown identifiers drain without using the result register
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_hit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = s1_fire && s1_hit;

  // Channel units
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    assign chan_en[g] = out_load && (int'(s1_chan) == g);

    cmsfd_chan #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (chan_en[g]),
      .data_byte(s1_byte_r),
      .res      (chan_res[g])
    );
  end

  // Select the addressed channel's result
  always_comb begin
    sel_res = '0;
    for (int g = 0; g < NUM_CHANNELS; g++) begin
      if (int'(s1_chan) == g) sel_res = chan_res[g];
    end
  end

  // Valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sid_r  <= in_ch.source_id;
      s1_byte_r <= in_ch.data_byte;
    end
    if (out_load) begin
      out_chan_r <= s1_chan;
      out_byte_r <= s1_byte_r;
      out_res_r  <= sel_res;
    end
  end

  // Result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel        = out_chan_r;
  assign out_ch.byte_out       = out_byte_r;
  assign out_ch.stored         = out_res_r.stored;
  assign out_ch.byte_index     = out_res_r.byte_index;
  assign out_ch.message_done   = out_res_r.message_done;
  assign out_ch.message_ok     = out_res_r.message_ok;
  assign out_ch.message_id     = out_res_r.message_id;
  assign out_ch.payload_length = out_res_r.payload_length;

endmodule

// ===== dv/can_multi_source_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// can_multi_source_frame_deframer_tb
// Self-checking bench for the multi-source CAN frame deframer. A short table
// of bytes comes first: reset values, extreme identifiers and bytes, one
// complete message and a broken sync. Random traffic follows on all three
// channels. It is mostly well-formed messages with random content, with
// wrong lengths, restarts, partial patterns, stray identifiers and a few long
// messages that run into the buffer bound. Each result is checked against a
// behavioural model of the per-channel state. The run cycles through phases
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module can_multi_source_frame_deframer_tb;
  import cmsfd_pkg::*;

  localparam int NCH            = 3;
  localparam int MAX_BYTES      = 256;
  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int LONG_BODY      = 253;

  // One result item as seen on the output channel
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] byte_out;
    logic              stored;
    logic [IDX_W-1:0]  byte_index;
    logic              message_done;
    logic              message_ok;
    logic [WORD_W-1:0] message_id;
    logic [WORD_W-1:0] payload_length;
  } frame_res_t;

  // One row of the directed table; typed rows carry their result by hand
  typedef struct {
    logic [SID_W-1:0]  sid;
    logic [BYTE_W-1:0] val;
    bit                typed;
    frame_res_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  cmsfd_in_if  in_bus ();
  cmsfd_out_if out_bus ();

  can_multi_source_frame_deframer #(
    .NUM_CHANNELS      (NCH),
    .MAX_MESSAGE_BYTES (MAX_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Model state, one entry per channel
  sync_st_t          hdr_st   [NCH];
  sync_st_t          ftr_st   [NCH];
  logic              coll     [NCH];
  int unsigned       byte_cnt [NCH];
  logic [BYTE_W-1:0] len_lo   [NCH];
  logic [WORD_W-1:0] msg_len  [NCH];
  logic [WORD_W-1:0] msg_id   [NCH];

  frame_res_t        pending_results [$];
  logic [BYTE_W-1:0] byte_plan [NCH][$];
  logic [SID_W-1:0]  chan_sid  [NCH] = '{CHAN0_ID, CHAN1_ID, CHAN2_ID};

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_fed     = 0;
  int unsigned results_seen  = 0;
  int unsigned msgs_closed   = 0;
  int unsigned msgs_good     = 0;
  int unsigned errors_seen   = 0;
  frame_res_t  exp_r;

  // Step an a-b-a-b search; returns 1 when the pattern completes
  function automatic bit sync_step(input sync_st_t cur, input logic [BYTE_W-1:0] b,
                                   input logic [BYTE_W-1:0] first,
                                   input logic [BYTE_W-1:0] second,
                                   output sync_st_t nxt);
    nxt = SYNC_IDLE;
    if (b == first) begin
      if (cur == SYNC_IDLE) nxt = SYNC_A;
      else if (cur == SYNC_AB) nxt = SYNC_ABA;
      return 1'b0;
    end
    if (b == second && cur == SYNC_A) nxt = SYNC_AB;
    return (b == second && cur == SYNC_ABA);
  endfunction

  // Work out the result of one byte and advance the channel's state
  function automatic bit deframe_byte(input logic [SID_W-1:0] sid,
                                      input logic [BYTE_W-1:0] b,
                                      output frame_res_t r);
    int          ch;
    int unsigned n;
    sync_st_t    nxt;
    bit          hit;
    ch = -1;
    r  = '0;
    if (sid == CHAN0_ID) ch = 0;
    else if (sid == CHAN1_ID) ch = 1;
    else if (sid == CHAN2_ID) ch = 2;
    if (ch < 0 || ch >= NCH) return 1'b0;
    r.channel  = CHAN_W'(ch);
    r.byte_out = b;
    // collection first
    if (coll[ch]) begin
      n = byte_cnt[ch];
      if (n < MAX_BYTES) begin
        r.stored     = 1'b1;
        r.byte_index = IDX_W'(n);
        case (n)
          0: msg_id[ch][7:0]  = b;
          1: msg_id[ch][15:8] = b;
          2: len_lo[ch]       = b;
          3: msg_len[ch]      = {b, len_lo[ch]};
          default: ;
        endcase
      end
      n++;
      byte_cnt[ch] = n;
      if (n > int'(msg_len[ch]) + FRAME_OVERHEAD || n > MAX_BYTES) coll[ch] = 1'b0;
    end
    // then the header search
    hit = sync_step(hdr_st[ch], b, HDR_FIRST, HDR_SECOND, nxt);
    hdr_st[ch] = nxt;
    if (hit) begin
      coll[ch]     = 1'b1;
      byte_cnt[ch] = 0;
    end
    // then the footer search
    hit = sync_step(ftr_st[ch], b, FTR_FIRST, FTR_SECOND, nxt);
    ftr_st[ch] = nxt;
    if (hit && coll[ch]) begin
      r.message_done = 1'b1;
      r.message_ok   = (byte_cnt[ch] == int'(msg_len[ch]) + FRAME_OVERHEAD);
      coll[ch]       = 1'b0;
    end
    r.message_id     = msg_id[ch];
    r.payload_length = msg_len[ch];
    return 1'b1;
  endfunction

  // Random byte leaning towards the pattern bytes
  function automatic logic [BYTE_W-1:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return HDR_FIRST;
      1: return HDR_SECOND;
      2: return FTR_FIRST;
      3: return FTR_SECOND;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Queue the first n bytes of an a-b-a-b pattern
  task automatic push_pattern(input int ch, input logic [BYTE_W-1:0] first,
                              input logic [BYTE_W-1:0] second, input int n);
    for (int i = 0; i < n; i++) byte_plan[ch].push_back((i % 2 == 0) ? first : second);
  endtask

  // Queue sync, id, declared length, body and footer
  task automatic push_message(input int ch, input int unsigned decl_len,
                              input int unsigned body_len);
    logic [WORD_W-1:0] len16;
    logic [WORD_W-1:0] id16;
    len16 = WORD_W'(decl_len);
    id16  = WORD_W'($urandom);
    push_pattern(ch, HDR_FIRST, HDR_SECOND, 4);
    byte_plan[ch].push_back(id16[7:0]);
    byte_plan[ch].push_back(id16[15:8]);
    byte_plan[ch].push_back(len16[7:0]);
    byte_plan[ch].push_back(len16[15:8]);
    repeat (body_len) byte_plan[ch].push_back(BYTE_W'($urandom));
    push_pattern(ch, FTR_FIRST, FTR_SECOND, 4);
  endtask

  // Plan the next run of bytes for one channel; kind 0 is a long message
  task automatic plan_sequence(input int ch, input int unsigned kind);
    int unsigned body_len;
    int unsigned decl_len;
    body_len = $urandom_range(0, 10);
    if (kind < 1) begin
      // long enough to run past the buffer bound before the footer
      push_message(ch, $urandom_range(249, 400), LONG_BODY);
    end else if (kind < 62) begin
      push_message(ch, body_len, body_len);
    end else if (kind < 77) begin
      // declared length disagrees with the body
      if ($urandom_range(0, 1)) decl_len = $urandom_range(0, 65535);
      else if (body_len > 0 && $urandom_range(0, 1)) decl_len = body_len - 1;
      else decl_len = body_len + 1;
      push_message(ch, decl_len, body_len);
    end else if (kind < 82) begin
      // a pattern cut short, then noise
      if ($urandom_range(0, 1)) push_pattern(ch, HDR_FIRST, HDR_SECOND, $urandom_range(1, 3));
      else push_pattern(ch, FTR_FIRST, FTR_SECOND, $urandom_range(1, 4));
      repeat ($urandom_range(1, 4)) byte_plan[ch].push_back(noisy_byte());
    end else if (kind < 88) begin
      // a fresh sync part-way through a message restarts collection
      push_pattern(ch, HDR_FIRST, HDR_SECOND, 4);
      repeat ($urandom_range(0, 5)) byte_plan[ch].push_back(BYTE_W'($urandom));
      push_message(ch, body_len, body_len);
    end else begin
      repeat ($urandom_range(1, 8)) byte_plan[ch].push_back(noisy_byte());
    end
  endtask

  // Offer one item, wait for it to be taken, then log what it should give
  task automatic send_byte(input logic [SID_W-1:0] sid, input logic [BYTE_W-1:0] b,
                           input bit typed, input frame_res_t typed_res);
    frame_res_t pred;
    bit         hit;
    @(negedge clk);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_bus.valid     <= 1'b1;
    in_bus.source_id <= sid;
    in_bus.data_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    hit = deframe_byte(sid, b, pred);
    if (hit) begin
      pending_results.push_back(typed ? typed_res : pred);
      items_fed++;
    end
  endtask

  // Hold the sender off until every expected result has arrived
  task automatic settle_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    row_t        directed [$];
    frame_res_t  blank;
    int          ch;
    int unsigned phase_base;
    in_bus.valid     = 1'b0;
    in_bus.source_id = '0;
    in_bus.data_byte = '0;
    rst_n            = 1'b0;
    blank            = '0;
    for (int c = 0; c < NCH; c++) begin
      hdr_st[c]   = SYNC_IDLE;
      ftr_st[c]   = SYNC_IDLE;
      coll[c]     = 1'b0;
      byte_cnt[c] = 0;
      len_lo[c]   = '0;
      msg_len[c]  = '0;
      msg_id[c]   = '0;
    end

    // after reset, extremes and stray identifiers
    directed.push_back('{CHAN0_ID, 8'h00, 1'b1, '{2'd0, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0,
                                                 16'h0000, 16'h0000}});
    directed.push_back('{11'h000, 8'hFF, 1'b0, blank});
    directed.push_back('{11'h7FF, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN2_ID, 8'hFF, 1'b1, '{2'd2, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0,
                                                 16'h0000, 16'h0000}});
    // footer byte with nothing being collected
    directed.push_back('{CHAN1_ID, FTR_FIRST, 1'b1, '{2'd1, 8'h66, 1'b0, 8'd0, 1'b0, 1'b0,
                                                      16'h0000, 16'h0000}});
    // a complete empty-payload message with id 0x1234 on channel 0
    directed.push_back('{CHAN0_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN0_ID, HDR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN0_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN0_ID, HDR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN0_ID, 8'h34, 1'b0, blank});
    directed.push_back('{11'h000, HDR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN0_ID, 8'h12, 1'b0, blank});
    directed.push_back('{CHAN0_ID, 8'h00, 1'b0, blank});
    directed.push_back('{CHAN0_ID, 8'h00, 1'b0, blank});
    directed.push_back('{CHAN0_ID, FTR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN0_ID, FTR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN0_ID, FTR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN0_ID, FTR_SECOND, 1'b1, '{2'd0, 8'hCC, 1'b1, 8'd7, 1'b1, 1'b1,
                                                      16'h1234, 16'h0000}});
    // a repeated 55 breaks the sync, which then completes on a clean run
    directed.push_back('{CHAN2_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_SECOND, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_FIRST, 1'b0, blank});
    directed.push_back('{CHAN2_ID, HDR_SECOND, 1'b0, blank});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_byte(directed[i].sid, directed[i].val, directed[i].typed, directed[i].res);
    settle_results();

    // random traffic, one idling profile per phase
    phase_base = items_fed;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      if (phase % 2 == 0) plan_sequence($urandom_range(0, NCH - 1), 0);
      while (items_fed < phase_base + (phase + 1) * RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 99) < 8) begin
          send_byte(SID_W'($urandom_range(0, 2047)), BYTE_W'($urandom), 1'b0, blank);
        end else begin
          ch = $urandom_range(0, NCH - 1);
          if (byte_plan[ch].size() == 0) plan_sequence(ch, $urandom_range(0, 99));
          send_byte(chan_sid[ch], byte_plan[ch].pop_front(), 1'b0, blank);
        end
      end
      settle_results();
    end

    // let any late result show up
    stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("Summary: %0d bytes on known identifiers, %0d results checked,",
             items_fed, results_seen);
    $display("  %0d messages closed (%0d with matching length), 4 idling phases, %0d errors",
             msgs_closed, msgs_good, errors_seen);
    if (errors_seen == 0 && pending_results.size() == 0) begin
      $display("[can_multi_source_frame_deframer] OK");
    end else begin
      $display("[can_multi_source_frame_deframer] ERROR");
    end
    $finish;
  end

  // Receiver: random stalls changed at the falling edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
                                      input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors_seen++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: channel %0d byte %0h",
               out_bus.channel, out_bus.byte_out);
        errors_seen++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("channel",        exp_r.channel,        out_bus.channel);
        check_field("byte_out",       exp_r.byte_out,       out_bus.byte_out);
        check_field("stored",         exp_r.stored,         out_bus.stored);
        check_field("byte_index",     exp_r.byte_index,     out_bus.byte_index);
        check_field("message_done",   exp_r.message_done,   out_bus.message_done);
        check_field("message_ok",     exp_r.message_ok,     out_bus.message_ok);
        check_field("message_id",     exp_r.message_id,     out_bus.message_id);
        check_field("payload_length", exp_r.payload_length, out_bus.payload_length);
        results_seen++;
        if (exp_r.message_done) msgs_closed++;
        if (exp_r.message_done && exp_r.message_ok) msgs_good++;
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[can_multi_source_frame_deframer] ERROR");
    $finish;
  end

endmodule
